FILE: rtl/core/assert_macros.svh
// Assertion macros for the controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked assertion, disabled while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion, also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: rtl/core/bfh_pkg.sv
// Types and constants of the boiler fill and heat controller.
`timescale 1ns / 1ps
package bfh_pkg;

  // Default width of the hysteresis countdown
  localparam int unsigned COUNT_BITS_DEF = 8;

  // Configuration port widths and register indexes
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned HYST_W     = 8;
  localparam logic [CFG_IDX_W-1:0] REG_HYST_TENTHS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEST_MODE   = 8'd1;
  localparam logic [HYST_W-1:0]    HYST_RESET      = 8'd10;

  // Controller states
  typedef enum logic [2:0] {
    ST_OFF       = 3'd0,
    ST_HYST      = 3'd1,
    ST_FILL      = 3'd2,
    ST_FILL_HEAT = 3'd3,
    ST_HEAT      = 3'd4
  } state_t;

  // Event codes of an input beat
  typedef enum logic [1:0] {
    EV_TOGGLE  = 2'd0,
    EV_LEVEL   = 2'd1,
    EV_TICK    = 2'd2,
    EV_REFRESH = 2'd3
  } cmd_t;

  // One result beat
  typedef struct packed {
    logic [2:0] ctrl_state;
    logic       heater_on;
    logic       pump_on;
    logic       heater_relay;
    logic       pump_relay;
    logic       display_update;
    logic       state_moved;
  } result_t;

  // Status of the state machine seen by the top level
  typedef struct packed {
    state_t state;
    logic   wait_zero;
    logic   heater_relay;
    logic   pump_relay;
  } status_t;

endpackage

FILE: rtl/core/bfh_in_if.sv
// Input event channel: valid/ready plus event code and level flag.
`timescale 1ns / 1ps
interface bfh_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic       boiler_full;

  modport source (output valid, output cmd, output boiler_full, input ready);
  modport sink (input valid, input cmd, input boiler_full, output ready);
endinterface

FILE: rtl/core/bfh_out_if.sv
// Result channel: valid/ready plus state and heater/pump flags.
`timescale 1ns / 1ps
interface bfh_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] ctrl_state;
  logic       heater_on;
  logic       pump_on;
  logic       heater_relay;
  logic       pump_relay;
  logic       display_update;
  logic       state_moved;

  modport source (
    output valid, output ctrl_state, output heater_on, output pump_on,
    output heater_relay, output pump_relay, output display_update,
    output state_moved, input ready
  );
  modport sink (
    input valid, input ctrl_state, input heater_on, input pump_on,
    input heater_relay, input pump_relay, input display_update,
    input state_moved, output ready
  );
endinterface

FILE: rtl/core/bfh_cfg_if.sv
// Configuration write channel: valid/ready plus register index and data.
`timescale 1ns / 1ps
interface bfh_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bfh_pkg::CFG_IDX_W-1:0]  index;
  logic [bfh_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/bfh_fsm.sv
// Controller state machine: state, countdown, flags and relays.
`timescale 1ns / 1ps
module bfh_fsm #(
  parameter int unsigned COUNT_BITS = bfh_pkg::COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  bfh_pkg::cmd_t               cmd,
  input  logic                        boiler_full,
  input  logic [bfh_pkg::HYST_W-1:0]  hyst_tenths,
  input  logic                        test_mode,
  output bfh_pkg::result_t            result,
  output bfh_pkg::status_t            status
);

  localparam int unsigned SatW = (COUNT_BITS > bfh_pkg::HYST_W) ? COUNT_BITS
                                                                : bfh_pkg::HYST_W;

  bfh_pkg::state_t        state_r, state_nxt;
  logic [COUNT_BITS-1:0]  wait_r, wait_nxt;
  logic                   heater_r, heater_nxt;
  logic                   pump_r, pump_nxt;
  logic                   hrelay_r, hrelay_nxt;
  logic                   prelay_r, prelay_nxt;
  logic                   moved;
  logic                   drv_h, drv_p, h_val, p_val;
  logic [SatW-1:0]        hyst_ext, cnt_max_ext;
  logic [COUNT_BITS-1:0]  wait_load;

  // Countdown load, saturated to the counter width
  assign hyst_ext    = SatW'(hyst_tenths);
  assign cnt_max_ext = SatW'({COUNT_BITS{1'b1}});
  assign wait_load   = (hyst_ext > cnt_max_ext) ? {COUNT_BITS{1'b1}}
                                                : COUNT_BITS'(hyst_ext);

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bfh_pkg::ST_OFF;
      wait_r   <= '0;
      heater_r <= 1'b0;
      pump_r   <= 1'b0;
      hrelay_r <= 1'b0;
      prelay_r <= 1'b0;
    end else if (step) begin
      state_r  <= state_nxt;
      wait_r   <= wait_nxt;
      heater_r <= heater_nxt;
      pump_r   <= pump_nxt;
      hrelay_r <= hrelay_nxt;
      prelay_r <= prelay_nxt;
    end
  end

  // Next state and flag commands
  always_comb begin
    state_nxt = state_r;
    wait_nxt  = wait_r;
    moved     = 1'b0;
    drv_h     = 1'b0;
    drv_p     = 1'b0;
    h_val     = 1'b0;
    p_val     = 1'b0;
    unique case (state_r)
      bfh_pkg::ST_HYST: begin
        unique case (cmd)
          bfh_pkg::EV_LEVEL: begin
            if (boiler_full) begin
              wait_nxt  = '0;
              drv_h = 1'b1; h_val = 1'b1;
              drv_p = 1'b1; p_val = 1'b0;
              state_nxt = bfh_pkg::ST_HEAT;
              moved     = 1'b1;
            end
          end
          bfh_pkg::EV_REFRESH: begin
            drv_h = 1'b1; drv_p = 1'b1;
          end
          bfh_pkg::EV_TOGGLE: begin
            wait_nxt  = '0;
            drv_h = 1'b1; drv_p = 1'b1;
            state_nxt = bfh_pkg::ST_OFF;
            moved     = 1'b1;
          end
          default: begin
            // tick: count down, refill while heating at expiry
            if (wait_r <= COUNT_BITS'(1)) begin
              wait_nxt  = '0;
              drv_h = 1'b1; h_val = 1'b1;
              drv_p = 1'b1; p_val = 1'b1;
              state_nxt = bfh_pkg::ST_FILL_HEAT;
              moved     = 1'b1;
            end else begin
              wait_nxt = wait_r - COUNT_BITS'(1);
            end
          end
        endcase
      end
      bfh_pkg::ST_FILL, bfh_pkg::ST_FILL_HEAT: begin
        unique case (cmd)
          bfh_pkg::EV_LEVEL: begin
            if (boiler_full) begin
              drv_h = 1'b1; h_val = 1'b1;
              drv_p = 1'b1; p_val = 1'b0;
              state_nxt = bfh_pkg::ST_HEAT;
              moved     = 1'b1;
            end
          end
          bfh_pkg::EV_REFRESH: begin
            drv_h = 1'b1; h_val = (state_r == bfh_pkg::ST_FILL_HEAT);
            drv_p = 1'b1; p_val = 1'b1;
          end
          bfh_pkg::EV_TOGGLE: begin
            drv_h = 1'b1; drv_p = 1'b1;
            state_nxt = bfh_pkg::ST_OFF;
            moved     = 1'b1;
          end
          default: ;
        endcase
      end
      bfh_pkg::ST_HEAT: begin
        unique case (cmd)
          bfh_pkg::EV_LEVEL: begin
            // level lost: start the hysteresis wait
            if (!boiler_full) begin
              wait_nxt  = wait_load;
              state_nxt = bfh_pkg::ST_HYST;
              moved     = 1'b1;
            end
          end
          bfh_pkg::EV_REFRESH: begin
            drv_h = 1'b1; h_val = 1'b1;
            drv_p = 1'b1; p_val = 1'b0;
          end
          bfh_pkg::EV_TOGGLE: begin
            drv_h = 1'b1; drv_p = 1'b1;
            state_nxt = bfh_pkg::ST_OFF;
            moved     = 1'b1;
          end
          default: ;
        endcase
      end
      default: begin
        // off, and unused codes
        unique case (cmd)
          bfh_pkg::EV_REFRESH: begin
            drv_h = 1'b1; drv_p = 1'b1;
          end
          bfh_pkg::EV_TOGGLE: begin
            drv_h = 1'b1; h_val = boiler_full;
            drv_p = 1'b1; p_val = !boiler_full;
            state_nxt = boiler_full ? bfh_pkg::ST_HEAT : bfh_pkg::ST_FILL;
            moved     = 1'b1;
          end
          default: ;
        endcase
      end
    endcase
  end

  // Flags follow commands; relays too unless in test mode
  always_comb begin
    heater_nxt = drv_h ? h_val : heater_r;
    pump_nxt   = drv_p ? p_val : pump_r;
    hrelay_nxt = (drv_h && !test_mode) ? h_val : hrelay_r;
    prelay_nxt = (drv_p && !test_mode) ? p_val : prelay_r;
  end

  // Result of this beat and status
  always_comb begin
    result.ctrl_state     = state_nxt;
    result.heater_on      = heater_nxt;
    result.pump_on        = pump_nxt;
    result.heater_relay   = hrelay_nxt;
    result.pump_relay     = prelay_nxt;
    result.display_update = (heater_nxt != heater_r) || (pump_nxt != pump_r);
    result.state_moved    = moved;
    status.state          = state_r;
    status.wait_zero      = (wait_r == '0);
    status.heater_relay   = hrelay_r;
    status.pump_relay     = prelay_r;
  end

endmodule

FILE: rtl/core/boiler_fill_heat_controller.sv
// Top level of the boiler fill and heat controller.
//
//   channel  | dir | beat contents
//   ---------+-----+-----------------------------------------------------
//   in_bus   | in  | cmd (event code), boiler_full
//   out_bus  | out | ctrl_state, heater/pump flags, relays, change flags
//   cfg_bus  | in  | index, data (hysteresis_tenths, test_mode)
//
// One event per clock while out_bus is not stalled: the state machine updates on
// the accepting edge and the result lands in the output register at that same edge.
// in_bus is ready whenever the output register is empty or being drained.
// A stalled result holds; cfg_bus is always ready, no reset sweep needed.
// rst_n is synchronous, active low.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module boiler_fill_heat_controller #(
  parameter int unsigned COUNT_BITS = bfh_pkg::COUNT_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  bfh_in_if.sink   in_bus,
  bfh_out_if.source out_bus,
  bfh_cfg_if.sink  cfg_bus
);

  logic [bfh_pkg::HYST_W-1:0] hyst_r;
  logic                       test_mode_r;
  logic                       out_valid_r;
  bfh_pkg::result_t           out_r;
  bfh_pkg::result_t           result;
  bfh_pkg::status_t           status;
  logic                       in_acc;

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign in_acc       = in_bus.valid && in_bus.ready;

  // Configuration registers
  assign cfg_bus.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hyst_r      <= bfh_pkg::HYST_RESET;
      test_mode_r <= 1'b0;
    end else if (cfg_bus.valid) begin
      if (cfg_bus.index == bfh_pkg::REG_HYST_TENTHS) begin
        hyst_r <= cfg_bus.data[bfh_pkg::HYST_W-1:0];
      end else if (cfg_bus.index == bfh_pkg::REG_TEST_MODE) begin
        test_mode_r <= cfg_bus.data[0];
      end
    end
  end

  bfh_fsm #(
    .COUNT_BITS (COUNT_BITS)
  ) u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_acc),
    .cmd         (bfh_pkg::cmd_t'(in_bus.cmd)),
    .boiler_full (in_bus.boiler_full),
    .hyst_tenths (hyst_r),
    .test_mode   (test_mode_r),
    .result      (result),
    .status      (status)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r <= result;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.ctrl_state     = out_r.ctrl_state;
  assign out_bus.heater_on      = out_r.heater_on;
  assign out_bus.pump_on        = out_r.pump_on;
  assign out_bus.heater_relay   = out_r.heater_relay;
  assign out_bus.pump_relay     = out_r.pump_relay;
  assign out_bus.display_update = out_r.display_update;
  assign out_bus.state_moved    = out_r.state_moved;

  // Checks
  `ASSERT_CLK(a_heat_flags, clk, rst_n, (out_valid_r && out_r.ctrl_state == bfh_pkg::ST_HEAT) |-> (out_r.heater_on && !out_r.pump_on), "heating result without heater on and pump off")
  `ASSERT_CLK(a_wait_idle, clk, rst_n, (status.state != bfh_pkg::ST_HYST) |-> status.wait_zero, "countdown running outside hysteresis")
  `ASSERT_CLK(a_test_freeze, clk, rst_n, (in_acc && test_mode_r) |=> ($stable(status.heater_relay) && $stable(status.pump_relay)), "relay moved in test mode")
  `ASSERT_CLK(a_beat_kept, clk, rst_n, in_acc |=> out_valid_r, "accepted beat produced no result")

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the boiler fill and heat controller.
`timescale 1ns / 1ps
module testbench;
  import bfh_pkg::*;

  localparam int unsigned COUNT_BITS    = COUNT_BITS_DEF;
  localparam int unsigned CNT_MAX       = (1 << COUNT_BITS) - 1;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned PHASES        = 9;
  localparam int unsigned PHASE_ITEMS   = 105;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd7;

  // Stimulus row: a register write or an event beat, optionally with a fixed expectation
  typedef struct packed {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    cmd_t                  cmd;
    logic                  full;
    bit                    pinned;
    result_t               val;
  } step_t;

  typedef struct packed {
    bit      pinned;
    result_t val;
  } fixed_t;

  logic clk = 1'b0;
  logic rst_n;

  bfh_in_if  in_bus();
  bfh_out_if out_bus();
  bfh_cfg_if cfg_bus();

  boiler_fill_heat_controller dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus),
    .cfg_bus(cfg_bus)
  );

  always #5 clk = ~clk;

  // Controller model state and configuration
  state_t                cur_st;
  logic [COUNT_BITS-1:0] wait_cnt;
  logic                  heat_flag, pump_flag, heat_rly, pump_rly;
  logic [HYST_W-1:0]     hyst;
  logic                  tmode;

  result_t expected_status[$];
  fixed_t  fixed_status[$];
  int      mismatches = 0;
  bit      calm = 1'b0;
  bit      hold_req = 1'b0;

  function automatic void set_heater(logic on);
    heat_flag = on;
    if (!tmode) heat_rly = on;
  endfunction

  function automatic void set_pump(logic on);
    pump_flag = on;
    if (!tmode) pump_rly = on;
  endfunction

  // Advance the controller model by one event and return its status beat
  function automatic result_t boiler_step(cmd_t c, logic full);
    result_t r;
    logic    old_h, old_p, moved;
    state_t  nxt;
    old_h = heat_flag;
    old_p = pump_flag;
    nxt   = cur_st;
    moved = 1'b0;
    case (cur_st)
      ST_HYST: begin
        case (c)
          EV_LEVEL: if (full) begin
            wait_cnt = '0;
            set_pump(1'b0);
            set_heater(1'b1);
            nxt   = ST_HEAT;
            moved = 1'b1;
          end
          EV_REFRESH: begin
            set_heater(1'b0);
            set_pump(1'b0);
          end
          EV_TOGGLE: begin
            wait_cnt = '0;
            set_heater(1'b0);
            set_pump(1'b0);
            nxt   = ST_OFF;
            moved = 1'b1;
          end
          default: begin
            // countdown expires at one or zero
            if (wait_cnt <= 1) begin
              wait_cnt = '0;
              set_heater(1'b1);
              set_pump(1'b1);
              nxt   = ST_FILL_HEAT;
              moved = 1'b1;
            end else begin
              wait_cnt = wait_cnt - 1'b1;
            end
          end
        endcase
      end
      ST_FILL, ST_FILL_HEAT: begin
        case (c)
          EV_LEVEL: if (full) begin
            set_heater(1'b1);
            set_pump(1'b0);
            nxt   = ST_HEAT;
            moved = 1'b1;
          end
          EV_REFRESH: begin
            set_heater(cur_st == ST_FILL_HEAT);
            set_pump(1'b1);
          end
          EV_TOGGLE: begin
            set_pump(1'b0);
            set_heater(1'b0);
            nxt   = ST_OFF;
            moved = 1'b1;
          end
          default: ;
        endcase
      end
      ST_HEAT: begin
        case (c)
          EV_LEVEL: if (!full) begin
            // load the countdown, saturated to the counter width
            wait_cnt = (int'(hyst) > CNT_MAX) ? CNT_MAX[COUNT_BITS-1:0] : hyst;
            nxt   = ST_HYST;
            moved = 1'b1;
          end
          EV_REFRESH: begin
            set_heater(1'b1);
            set_pump(1'b0);
          end
          EV_TOGGLE: begin
            set_pump(1'b0);
            set_heater(1'b0);
            nxt   = ST_OFF;
            moved = 1'b1;
          end
          default: ;
        endcase
      end
      default: begin
        // off, and any unused code, behave the same
        if (c == EV_REFRESH) begin
          set_heater(1'b0);
          set_pump(1'b0);
        end else if (c == EV_TOGGLE) begin
          set_pump(!full);
          set_heater(full);
          nxt   = full ? ST_HEAT : ST_FILL;
          moved = 1'b1;
        end
      end
    endcase
    cur_st           = nxt;
    r.ctrl_state     = cur_st;
    r.heater_on      = heat_flag;
    r.pump_on        = pump_flag;
    r.heater_relay   = heat_rly;
    r.pump_relay     = pump_rly;
    r.display_update = (old_h != heat_flag) || (old_p != pump_flag);
    r.state_moved    = moved;
    return r;
  endfunction

  task automatic check_field(string fld, logic [2:0] exp_v, logic [2:0] got_v);
    if (got_v !== exp_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, exp_v, got_v);
    end
  endtask

  // Monitor: register writes, status beats and event beats
  always @(posedge clk) begin : monitor
    result_t got, want;
    fixed_t  fx;
    if (!rst_n) begin
      cur_st    = ST_OFF;
      wait_cnt  = '0;
      heat_flag = 1'b0;
      pump_flag = 1'b0;
      heat_rly  = 1'b0;
      pump_rly  = 1'b0;
      hyst      = HYST_RESET;
      tmode     = 1'b0;
      expected_status.delete();
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        if (cfg_bus.index == REG_HYST_TENTHS) hyst = cfg_bus.data[HYST_W-1:0];
        else if (cfg_bus.index == REG_TEST_MODE) tmode = cfg_bus.data[0];
      end
      if (out_bus.valid && out_bus.ready) begin
        got.ctrl_state     = out_bus.ctrl_state;
        got.heater_on      = out_bus.heater_on;
        got.pump_on        = out_bus.pump_on;
        got.heater_relay   = out_bus.heater_relay;
        got.pump_relay     = out_bus.pump_relay;
        got.display_update = out_bus.display_update;
        got.state_moved    = out_bus.state_moved;
        if (expected_status.size() == 0) begin
          mismatches++;
          $display("%0t: status beat with nothing expected, actual %h", $time, got);
        end else begin
          want = expected_status.pop_front();
          check_field("ctrl_state", want.ctrl_state, got.ctrl_state);
          check_field("heater_on", want.heater_on, got.heater_on);
          check_field("pump_on", want.pump_on, got.pump_on);
          check_field("heater_relay", want.heater_relay, got.heater_relay);
          check_field("pump_relay", want.pump_relay, got.pump_relay);
          check_field("display_update", want.display_update, got.display_update);
          check_field("state_moved", want.state_moved, got.state_moved);
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        want = boiler_step(cmd_t'(in_bus.cmd), in_bus.boiler_full);
        fx   = fixed_status.pop_front();
        expected_status.push_back(fx.pinned ? fx.val : want);
      end
    end
  end

  // Watchdog on cycles with no beat on any channel
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Status receiver: random stalls, one long hold-off on request
  initial begin : receiver
    bit hold_taken;
    hold_taken = 1'b0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_bus.ready <= calm || ($urandom_range(99) >= 28);
      end
    end
  end

  task automatic push_event(cmd_t c, logic f, bit pinned = 1'b0, result_t val = '0);
    fixed_t fx;
    while (!calm && $urandom_range(99) < 28) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    fx.pinned = pinned;
    fx.val    = val;
    fixed_status.push_back(fx);
    in_bus.valid       <= 1'b1;
    in_bus.cmd         <= c;
    in_bus.boiler_full <= f;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // Leaves valid high so back-to-back writes need no drop
  task automatic cfg_beat(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  // Stop sending and wait for every expected status beat
  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(negedge clk); while (expected_status.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic step_t ev(cmd_t c, logic f);
    step_t s;
    s        = '0;
    s.cmd    = c;
    s.full   = f;
    return s;
  endfunction

  // flags: heater pump heater_relay pump_relay display_update state_moved
  function automatic step_t evx(cmd_t c, logic f, state_t st, logic [5:0] flags);
    step_t s;
    s        = ev(c, f);
    s.pinned = 1'b1;
    s.val    = {st, flags};
    return s;
  endfunction

  function automatic step_t wr(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    step_t s;
    s        = '0;
    s.is_cfg = 1'b1;
    s.idx    = idx;
    s.data   = data;
    return s;
  endfunction

  // Stimulus
  initial begin : stimulus
    step_t             dir_tab[$];
    bit                cfg_open;
    logic [HYST_W-1:0] hv;
    int unsigned       sent, pick, nt;

    rst_n              <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.cmd         <= EV_TOGGLE;
    in_bus.boiler_full <= 1'b0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.index      <= REG_HYST_TENTHS;
    cfg_bus.data       <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    dir_tab = '{
      // default settings: every event from off, then a walk through fill, heat and hysteresis
      evx(EV_REFRESH, 1'b0, ST_OFF,       6'b000000),
      evx(EV_TICK,    1'b1, ST_OFF,       6'b000000),
      evx(EV_LEVEL,   1'b1, ST_OFF,       6'b000000),
      evx(EV_TOGGLE,  1'b0, ST_FILL,      6'b010111),
      evx(EV_REFRESH, 1'b0, ST_FILL,      6'b010100),
      ev (EV_LEVEL,   1'b0),
      evx(EV_LEVEL,   1'b1, ST_HEAT,      6'b101011),
      evx(EV_REFRESH, 1'b1, ST_HEAT,      6'b101000),
      evx(EV_LEVEL,   1'b0, ST_HYST,      6'b101001),
      ev (EV_TICK,    1'b0),
      // level back before the countdown ends
      evx(EV_LEVEL,   1'b1, ST_HEAT,      6'b101001),
      evx(EV_LEVEL,   1'b0, ST_HYST,      6'b101001),
      evx(EV_REFRESH, 1'b0, ST_HYST,      6'b000010),
      ev (EV_LEVEL,   1'b0),
      evx(EV_TOGGLE,  1'b1, ST_OFF,       6'b000001),
      evx(EV_TOGGLE,  1'b1, ST_HEAT,      6'b101011),
      evx(EV_TOGGLE,  1'b0, ST_OFF,       6'b000011),
      // zero wait expires on the first tick; relays frozen
      wr(REG_HYST_TENTHS, 8'd0),
      wr(REG_TEST_MODE,   8'd1),
      evx(EV_TOGGLE,  1'b1, ST_HEAT,      6'b100011),
      evx(EV_LEVEL,   1'b0, ST_HYST,      6'b100001),
      evx(EV_TICK,    1'b0, ST_FILL_HEAT, 6'b110011),
      evx(EV_REFRESH, 1'b1, ST_FILL_HEAT, 6'b110000),
      evx(EV_TOGGLE,  1'b1, ST_OFF,       6'b000011),
      // longest wait; test mode bit masked off; write to an unused index
      wr(REG_HYST_TENTHS, 8'd255),
      wr(REG_TEST_MODE,   8'h02),
      wr(REG_SPARE,       8'h5A),
      evx(EV_TOGGLE,  1'b0, ST_FILL,      6'b010111),
      evx(EV_LEVEL,   1'b1, ST_HEAT,      6'b101011),
      evx(EV_LEVEL,   1'b0, ST_HYST,      6'b101001),
      ev (EV_TICK,    1'b1),
      evx(EV_TOGGLE,  1'b0, ST_OFF,       6'b000011)
    };

    // Directed walk
    cfg_open = 1'b0;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        if (!cfg_open) drain();
        cfg_beat(dir_tab[i].idx, dir_tab[i].data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) cfg_bus.valid <= 1'b0;
        cfg_open = 1'b0;
        push_event(dir_tab[i].cmd, dir_tab[i].full, dir_tab[i].pinned, dir_tab[i].val);
      end
    end

    // Random phases, each under its own settings
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: hv = 8'd0;
        1: hv = 8'd255;
        2: hv = 8'd1;
        default: hv = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                               : 8'($urandom_range(7, 2));
      endcase
      cfg_beat(REG_HYST_TENTHS, hv);
      cfg_beat(REG_TEST_MODE, {7'd0, (ph == 1 || ph == 5 || ph == 7)});
      cfg_bus.valid <= 1'b0;
      calm          <= (ph == 6);
      if (ph == 3) hold_req <= 1'b1;

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          push_event(cmd_t'($urandom_range(3)), 1'($urandom_range(1)));
          sent++;
        end else if (pick < 88) begin
          // start up, heat, lose the level, count down, maybe regain it
          nt = $urandom_range(int'(hv) + 1);
          // keep the burst within what is left of the phase
          if (nt + 4 > PHASE_ITEMS - sent) begin
            nt = (PHASE_ITEMS - sent > 4) ? PHASE_ITEMS - sent - 4 : 0;
          end
          push_event(EV_TOGGLE, 1'($urandom_range(1)));
          push_event(EV_LEVEL, 1'b1);
          push_event(EV_LEVEL, 1'b0);
          repeat (nt) push_event(($urandom_range(9) == 0) ? EV_REFRESH : EV_TICK,
                                 1'($urandom_range(1)));
          push_event(EV_LEVEL, 1'($urandom_range(1)));
          sent += nt + 4;
        end else begin
          nt = $urandom_range(int'(hv) + 2, 1);
          if (nt > PHASE_ITEMS - sent) nt = PHASE_ITEMS - sent;
          repeat (nt) push_event(EV_TICK, 1'($urandom_range(1)));
          sent += nt;
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
